// ===== design/pfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page map fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int NUM_PAGES = 32;
    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int CNT_W     = $clog2(NUM_PAGES + 1);
    localparam int RUN_W     = $clog2(NUM_PAGES / 2 + 1);
    localparam int REQ_W     = 6;

    typedef logic [7:0] owner_t;

    localparam owner_t FREE_OWNER = 8'd0;

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_RUNNING     = 2'd1;
    localparam logic [1:0] STAT_NO_MEM      = 2'd2;
    localparam logic [1:0] STAT_NOT_RUNNING = 2'd3;

    typedef struct packed {
        logic clear;
        logic step;
        logic flush;
    } trk_ctrl_t;

    typedef struct packed {
        logic             best_found;
        logic [IDX_W-1:0] best_start;
        logic [CNT_W-1:0] match_cnt;
        logic [RUN_W-1:0] runs;
    } trk_stat_t;

endpackage

// ===== design/pfa_page_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_page_mem
// Page owner store: one write and one registered read port a cycle.
// Per-entry valid bits make unwritten pages read as free after reset.
// ----------------------------------------------------------------------------
module pfa_page_mem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       we,
    input  logic [pfa_pkg::IDX_W-1:0]  waddr,
    input  pfa_pkg::owner_t            wdata,
    input  logic [pfa_pkg::IDX_W-1:0]  raddr,
    output pfa_pkg::owner_t            rdata
);
    import pfa_pkg::*;

    owner_t               mem [NUM_PAGES];
    logic [NUM_PAGES-1:0] valid_reg;
    owner_t               rd_word_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_word_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_word_reg : FREE_OWNER;

endmodule

// ===== design/pfa_run_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_run_tracker
// Shared scan unit: takes one page owner a cycle, tracks free runs and
// the chosen fit, counts pages owned by the id and counts occupied runs.
// ----------------------------------------------------------------------------
module pfa_run_tracker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pfa_pkg::trk_ctrl_t         ctrl,
    input  pfa_pkg::owner_t            owner,
    input  logic [pfa_pkg::IDX_W-1:0]  idx,
    input  pfa_pkg::owner_t            id,
    input  logic [pfa_pkg::REQ_W-1:0]  need,
    input  logic                       fit_mode,
    output pfa_pkg::trk_stat_t         stat
);
    import pfa_pkg::*;

    logic             prev_used_reg,  prev_used_next;
    logic [IDX_W-1:0] run_start_reg,  run_start_next;
    logic [CNT_W-1:0] run_len_reg,    run_len_next;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_start_reg, best_start_next;
    logic [CNT_W-1:0] best_len_reg,   best_len_next;
    logic [CNT_W-1:0] match_cnt_reg,  match_cnt_next;
    logic [RUN_W-1:0] runs_reg,       runs_next;

    logic used;
    logic is_match;
    logic cand_ok;

    always_comb begin
        // flush acts as a used page past the end, closing the last free run
        used     = ctrl.flush | (owner != FREE_OWNER);
        is_match = (id != FREE_OWNER) && (owner == id);
        cand_ok  = (run_len_reg >= CNT_W'(need)) &&
                   (!best_found_reg ||
                    (!fit_mode && (run_len_reg < best_len_reg)) ||
                    ( fit_mode && (run_len_reg > best_len_reg)));

        prev_used_next  = prev_used_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_found_next = best_found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        match_cnt_next  = match_cnt_reg;
        runs_next       = runs_reg;

        if (ctrl.clear) begin
            prev_used_next  = 1'b0;
            run_start_next  = '0;
            run_len_next    = '0;
            best_found_next = 1'b0;
            best_start_next = '0;
            best_len_next   = '0;
            match_cnt_next  = '0;
            runs_next       = '0;
        end else if (ctrl.step || ctrl.flush) begin
            if (used) begin
                // strict compare keeps the lowest start on ties
                if ((run_len_reg != '0) && cand_ok) begin
                    best_found_next = 1'b1;
                    best_start_next = run_start_reg;
                    best_len_next   = run_len_reg;
                end
                run_len_next = '0;
            end else begin
                if (run_len_reg == '0) begin
                    run_start_next = idx;
                end
                run_len_next = run_len_reg + CNT_W'(1);
            end
            if (ctrl.step) begin
                prev_used_next = used;
                if (used && !prev_used_reg) begin
                    runs_next = runs_reg + RUN_W'(1);
                end
                if (is_match) begin
                    match_cnt_next = match_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_used_reg  <= 1'b0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_found_reg <= 1'b0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            match_cnt_reg  <= '0;
            runs_reg       <= '0;
        end else begin
            prev_used_reg  <= prev_used_next;
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            best_found_reg <= best_found_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            match_cnt_reg  <= match_cnt_next;
            runs_reg       <= runs_next;
        end
    end

    assign stat.best_found = best_found_reg;
    assign stat.best_start = best_start_reg;
    assign stat.match_cnt  = match_cnt_reg;
    assign stat.runs       = runs_reg;

endmodule

// ===== design/page_map_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_map_fit_allocator
// Contiguous page allocator over a 32-page owner map, best or worst fit.
// ----------------------------------------------------------------------------
//  channel   dir  signals                        contents
//  s_        in   s_tvalid s_tready s_tdata      request: cmd, prog_id, req_units
//                 s_tuser
//  m_        out  m_tvalid m_tready m_tdata      result: status, start, units,
//                                                groups of four, fragments
//  cfg_      in   cfg_wr_en cfg_wr_data          fit_mode
//
// A request makes one scan pass over the page memory (one read a cycle), the
// req_units page writes of a successful allocate, and a second pass counting
// occupied runs. Ready only while idle.
// Reset clears the map (valid bits) and fit_mode; no clearing pass.
// A stalled result holds in the output register; the next request is
// taken meanwhile and waits at its end for the register to empty.
// ----------------------------------------------------------------------------
module page_map_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // prog_id[7:0], req_units[13:8], zero fill
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], start_page[6:2],
                                   // units_changed[12:7],
                                   // groups_of_four[16:13],
                                   // fragment_count[21:17], zero fill
);
    import pfa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SCAN      = 9'b000000010,
        S_SCAN_END  = 9'b000000100,
        S_FLUSH     = 9'b000001000,
        S_DECIDE    = 9'b000010000,
        S_WRITE     = 9'b000100000,
        S_COUNT     = 9'b001000000,
        S_COUNT_END = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t           state_reg,    state_next;
    logic [IDX_W-1:0] addr_reg,     addr_next;
    logic             rd_pend_reg,  rd_pend_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             fit_mode_reg;

    logic [IDX_W-1:0] rd_idx_reg;
    logic             cmd_reg;
    owner_t           id_reg;
    logic [REQ_W-1:0] need_reg;
    logic [IDX_W-1:0] wr_idx_reg,   wr_idx_next;
    logic [REQ_W-1:0] wr_left_reg,  wr_left_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [4:0]       res_start_reg,  res_start_next;
    logic [5:0]       res_units_reg,  res_units_next;
    logic [23:0]      m_tdata_reg,    m_tdata_next;

    logic             accept;
    logic             out_load;
    logic [6:0]       gsum;
    trk_ctrl_t        trk_ctrl;
    trk_stat_t        trk_stat;
    owner_t           rd_owner;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    owner_t           mem_wdata;

    pfa_page_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (addr_reg),
        .rdata   (rd_owner)
    );

    pfa_run_tracker u_trk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (trk_ctrl),
        .owner    (rd_owner),
        .idx      (rd_idx_reg),
        .id       (id_reg),
        .need     (need_reg),
        .fit_mode (fit_mode_reg),
        .stat     (trk_stat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_pend_next    = (state_reg == S_SCAN) || (state_reg == S_COUNT);
        wr_idx_next     = wr_idx_reg;
        wr_left_next    = wr_left_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_units_next  = res_units_reg;
        out_load        = 1'b0;
        trk_ctrl        = '0;
        trk_ctrl.step   = rd_pend_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = FREE_OWNER;
        gsum            = 7'(res_units_reg) + 7'd3;

        // free: release matching pages as the scan passes them
        if (rd_pend_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_END)) &&
            (cmd_reg == CMD_FREE) && (id_reg != FREE_OWNER) && (rd_owner == id_reg)) begin
            mem_we = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    trk_ctrl.clear = 1'b1;
                    addr_next      = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(NUM_PAGES - 1)) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                state_next = S_FLUSH;
            end
            S_FLUSH: begin
                trk_ctrl.flush = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE: begin
                res_start_next = '0;
                res_units_next = '0;
                state_next     = S_COUNT;
                if (cmd_reg == CMD_ALLOC) begin
                    if ((id_reg == FREE_OWNER) || (trk_stat.match_cnt != '0)) begin
                        res_status_next = STAT_RUNNING;
                    end else if ((need_reg == '0) || !trk_stat.best_found) begin
                        res_status_next = STAT_NO_MEM;
                    end else begin
                        res_status_next = STAT_OK;
                        res_start_next  = 5'(trk_stat.best_start);
                        res_units_next  = 6'(need_reg);
                        wr_idx_next     = trk_stat.best_start;
                        wr_left_next    = need_reg;
                        state_next      = S_WRITE;
                    end
                end else begin
                    res_units_next  = 6'(trk_stat.match_cnt);
                    res_status_next = (trk_stat.match_cnt != '0) ? STAT_OK
                                                                 : STAT_NOT_RUNNING;
                end
                if (state_next == S_COUNT) begin
                    trk_ctrl.clear = 1'b1;
                    addr_next      = '0;
                end
            end
            S_WRITE: begin
                mem_we       = 1'b1;
                mem_waddr    = wr_idx_reg;
                mem_wdata    = id_reg;
                wr_idx_next  = wr_idx_reg + IDX_W'(1);
                wr_left_next = wr_left_reg - REQ_W'(1);
                if (wr_left_reg == REQ_W'(1)) begin
                    trk_ctrl.clear = 1'b1;
                    addr_next      = '0;
                    state_next     = S_COUNT;
                end
            end
            S_COUNT: begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(NUM_PAGES - 1)) begin
                    state_next = S_COUNT_END;
                end
            end
            S_COUNT_END: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end

        m_tdata_next = {2'b00, 5'(trk_stat.runs), gsum[5:2],
                        res_units_reg, res_start_reg, res_status_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            fit_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                fit_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= addr_reg;
        wr_idx_reg     <= wr_idx_next;
        wr_left_reg    <= wr_left_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_units_reg  <= res_units_next;
        if (accept) begin
            cmd_reg  <= s_tuser[0];
            id_reg   <= s_tdata[7:0];
            need_reg <= s_tdata[13:8];
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |->
        ((7'(wr_idx_reg) + 7'(wr_left_reg)) <= 7'(NUM_PAGES)))
        else $error("allocation write runs past the page map");

    a_release_only_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (mem_wdata == FREE_OWNER)) |->
        ((cmd_reg == CMD_FREE) && (id_reg != FREE_OWNER)))
        else $error("page released outside a free request");

    a_ok_iff_units: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((m_tdata_reg[1:0] == STAT_OK) == (m_tdata_reg[12:7] != '0)))
        else $error("status and units changed disagree");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request taken while another is in progress");
`endif

endmodule
